// ===== design/nrmc_pkg.sv =====
`default_nettype none
package nrmc_pkg;

    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_M     = 8'h4d;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    // field numbers, counted by commas
    localparam logic [3:0] FIELD_TIME   = 4'd1;
    localparam logic [3:0] FIELD_STATUS = 4'd2;
    localparam logic [3:0] FIELD_LAT    = 4'd3;
    localparam logic [3:0] FIELD_NS     = 4'd4;
    localparam logic [3:0] FIELD_LON    = 4'd5;
    localparam logic [3:0] FIELD_EW     = 4'd6;
    localparam logic [3:0] FIELD_DATE   = 4'd9;

    localparam logic [2:0] HDR_IDX_R = 3'd3;
    localparam logic [2:0] HDR_IDX_M = 3'd4;
    localparam logic [2:0] HDR_IDX_C = 3'd5;
    localparam logic [3:0] DIGITS_PER_FIELD = 4'd6;

    localparam logic [0:0] REG_ZONE   = 1'b0;
    localparam logic [4:0] ZONE_RESET = 5'd8;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;

    typedef logic [5:0][3:0] t_digits;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_sentence;
    } t_rmc_in;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic        fix_valid;
        logic [25:0] latitude;
        logic        lat_south;
        logic [29:0] longitude;
        logic        lon_west;
    } t_rmc_out;

    // raw sentence contents handed from the parser to the time/date unit
    typedef struct packed {
        t_digits     time_dig;
        t_digits     date_dig;
        logic [25:0] lat;
        logic [29:0] lon;
        logic        fix;
        logic        south;
        logic        west;
    } t_rec;

    function automatic logic [3:0] digit_of(input logic [7:0] b);
        logic [7:0] diff;
        diff = b - CHAR_ZERO;
        return (b >= CHAR_ZERO && b <= CHAR_NINE) ? diff[3:0] : 4'd0;
    endfunction

    function automatic logic [22:0] lat_weight(input logic [3:0] pos);
        logic [22:0] w;
        unique case (pos)
            4'd0:    w = 23'd6000000;
            4'd1:    w = 23'd600000;
            4'd2:    w = 23'd100000;
            4'd3:    w = 23'd10000;
            4'd5:    w = 23'd1000;
            4'd6:    w = 23'd100;
            4'd7:    w = 23'd10;
            4'd8:    w = 23'd1;
            default: w = 23'd0;
        endcase
        return w;
    endfunction

    function automatic logic [25:0] lon_weight(input logic [3:0] pos);
        logic [25:0] w;
        unique case (pos)
            4'd0:    w = 26'd60000000;
            4'd1:    w = 26'd6000000;
            4'd2:    w = 26'd600000;
            4'd3:    w = 26'd100000;
            4'd4:    w = 26'd10000;
            4'd6:    w = 26'd1000;
            4'd7:    w = 26'd100;
            4'd8:    w = 26'd10;
            4'd9:    w = 26'd1;
            default: w = 26'd0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mo);
        logic [4:0] n;
        unique case (mo)
            4'd2:                      n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
        return ({3'b0, hi} * 7'd10) + {3'b0, lo};
    endfunction

endpackage
`default_nettype wire

// ===== design/nrmc_front.sv =====
`default_nettype none
module nrmc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire nrmc_pkg::t_rmc_in i_data,
    output logic                   o_rec_wr,
    output nrmc_pkg::t_rec         o_rec
);
    import nrmc_pkg::*;

    logic [2:0]  r_byte_index, n_byte_index;
    logic        r_header_match, n_header_match;
    logic [3:0]  r_comma_count, n_comma_count;
    logic [3:0]  r_field_pos, n_field_pos;
    t_rec        r_acc, n_acc;

    logic [7:0]  b;
    logic [3:0]  d;
    logic        hdr_ok;
    logic [2:0]  u_byte_index;
    logic [3:0]  u_comma_count;
    logic [3:0]  u_field_pos;
    t_rec        u_acc;
    logic [26:0] lat_prod;
    logic [29:0] lon_prod;

    always_comb begin
        b = i_data.rx_byte;
        d = digit_of(b);
        lat_prod = {23'b0, d} * {4'b0, lat_weight(r_field_pos)};
        lon_prod = {26'b0, d} * {4'b0, lon_weight(r_field_pos)};

        hdr_ok = r_header_match &&
                 !((r_byte_index == HDR_IDX_R && b != CHAR_R) ||
                   (r_byte_index == HDR_IDX_M && b != CHAR_M) ||
                   (r_byte_index == HDR_IDX_C && b != CHAR_C));
        u_byte_index  = (r_byte_index != 3'd7) ? r_byte_index + 3'd1 : r_byte_index;
        u_comma_count = r_comma_count;
        u_field_pos   = r_field_pos;
        u_acc         = r_acc;

        if (b == CHAR_COMMA) begin
            u_comma_count = (r_comma_count != 4'd15) ? r_comma_count + 4'd1 : r_comma_count;
            u_field_pos   = 4'd0;
        end else begin
            unique case (r_comma_count)
                FIELD_TIME: begin
                    if (r_field_pos < DIGITS_PER_FIELD) u_acc.time_dig = {r_acc.time_dig[4:0], d};
                end
                FIELD_STATUS: begin
                    if (r_field_pos == 4'd0 && b == CHAR_A) u_acc.fix = 1'b1;
                end
                FIELD_LAT: begin
                    u_acc.lat = r_acc.lat + lat_prod[25:0];
                end
                FIELD_NS: begin
                    if (r_field_pos == 4'd0 && b == CHAR_S) u_acc.south = 1'b1;
                end
                FIELD_LON: begin
                    u_acc.lon = r_acc.lon + lon_prod;
                end
                FIELD_EW: begin
                    if (r_field_pos == 4'd0 && b == CHAR_W) u_acc.west = 1'b1;
                end
                FIELD_DATE: begin
                    if (r_field_pos < DIGITS_PER_FIELD) u_acc.date_dig = {r_acc.date_dig[4:0], d};
                end
                default: begin
                end
            endcase
            u_field_pos = (r_field_pos != 4'd15) ? r_field_pos + 4'd1 : r_field_pos;
        end

        o_rec    = u_acc;
        o_rec_wr = i_accept && i_data.end_of_sentence && hdr_ok && (r_byte_index >= HDR_IDX_C);

        n_byte_index   = r_byte_index;
        n_header_match = r_header_match;
        n_comma_count  = r_comma_count;
        n_field_pos    = r_field_pos;
        n_acc          = r_acc;
        if (i_accept) begin
            if (i_data.end_of_sentence) begin
                // sentence done: start over
                n_byte_index   = 3'd0;
                n_header_match = 1'b1;
                n_comma_count  = 4'd0;
                n_field_pos    = 4'd0;
                n_acc          = '0;
            end else begin
                n_byte_index   = u_byte_index;
                n_header_match = hdr_ok;
                n_comma_count  = u_comma_count;
                n_field_pos    = u_field_pos;
                n_acc          = u_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= 3'd0;
            r_header_match <= 1'b1;
            r_comma_count  <= 4'd0;
            r_field_pos    <= 4'd0;
            r_acc          <= '0;
        end else begin
            r_byte_index   <= n_byte_index;
            r_header_match <= n_header_match;
            r_comma_count  <= n_comma_count;
            r_field_pos    <= n_field_pos;
            r_acc          <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ===== design/nrmc_queue.sv =====
`default_nettype none
module nrmc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire nrmc_pkg::t_rec i_wr_rec,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_rd,
    output nrmc_pkg::t_rec      o_rd_rec
);
    import nrmc_pkg::*;

    t_rec       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_wr, do_rd;

    always_comb begin
        o_full   = (r_count == 2'd2);
        o_valid  = (r_count != 2'd0);
        o_rd_rec = r_mem[r_rd_ptr];
        do_wr    = i_wr && !o_full;
        do_rd    = i_rd && o_valid;
        n_wr_ptr = do_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_wr_rec;
    end

endmodule
`default_nettype wire

// ===== design/nrmc_back.sv =====
`default_nettype none
module nrmc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [4:0]     i_zone,
    input  wire logic           i_rec_valid,
    input  wire nrmc_pkg::t_rec i_rec,
    output logic                o_rec_rd,
    output logic                o_empty,
    input  wire logic           i_pop,
    output nrmc_pkg::t_rmc_out  o_data
);
    import nrmc_pkg::*;

    // stage 1: clamped UTC fields
    t_rmc_out   r_s1;
    logic       r_s1_valid, n_s1_valid;
    t_rmc_out   dec;
    t_rmc_out   rolled;

    // result buffer
    t_rmc_out   r_obuf [2];
    logic       r_owr_ptr, r_ord_ptr;
    logic [1:0] r_ocount;
    logic       s1_move, out_rd;

    logic [6:0] hh7, mm7, ss7, dd7, mo7, yy7;
    logic [4:0] zone_adj;
    logic [5:0] hsum;
    logic [5:0] dd_inc;
    logic [4:0] dim;

    always_comb begin
        hh7 = two_digit(i_rec.time_dig[5], i_rec.time_dig[4]);
        mm7 = two_digit(i_rec.time_dig[3], i_rec.time_dig[2]);
        ss7 = two_digit(i_rec.time_dig[1], i_rec.time_dig[0]);
        dd7 = two_digit(i_rec.date_dig[5], i_rec.date_dig[4]);
        mo7 = two_digit(i_rec.date_dig[3], i_rec.date_dig[2]);
        yy7 = two_digit(i_rec.date_dig[1], i_rec.date_dig[0]);

        dec.hour      = (hh7 > 7'd23) ? 5'd23 : hh7[4:0];
        dec.minute    = (mm7 > 7'd59) ? 6'd59 : mm7[5:0];
        dec.second    = (ss7 > 7'd59) ? 6'd59 : ss7[5:0];
        dec.day       = (dd7 == 7'd0) ? 5'd1 : ((dd7 > 7'd31) ? 5'd31 : dd7[4:0]);
        dec.month     = (mo7 == 7'd0) ? 4'd1 : ((mo7 > 7'd12) ? 4'd12 : mo7[3:0]);
        dec.year      = yy7;
        dec.fix_valid = i_rec.fix;
        dec.latitude  = i_rec.lat;
        dec.lat_south = i_rec.south;
        dec.longitude = i_rec.lon;
        dec.lon_west  = i_rec.west;
    end

    // stage 2: zone offset and calendar rollover
    always_comb begin
        zone_adj = (i_zone >= HOURS_PER_DAY) ? i_zone - HOURS_PER_DAY : i_zone;
        hsum     = {1'b0, r_s1.hour} + {1'b0, zone_adj};
        dd_inc   = {1'b0, r_s1.day} + 6'd1;
        dim      = (r_s1.month == 4'd2 && r_s1.year[1:0] == 2'b00) ? 5'd29
                                                                  : month_days(r_s1.month);
        rolled      = r_s1;
        rolled.hour = hsum[4:0];
        if (hsum >= {1'b0, HOURS_PER_DAY}) begin
            rolled.hour = 5'(hsum - {1'b0, HOURS_PER_DAY});
            rolled.day  = dd_inc[4:0];
            if (dd_inc > {1'b0, dim}) begin
                rolled.day   = 5'd1;
                rolled.month = r_s1.month + 4'd1;
                if (r_s1.month == 4'd12) begin
                    rolled.month = 4'd1;
                    rolled.year  = (r_s1.year >= 7'd99) ? 7'd0 : r_s1.year + 7'd1;
                end
            end
        end
    end

    always_comb begin
        s1_move    = r_s1_valid && (r_ocount != 2'd2);
        o_rec_rd   = i_rec_valid && (!r_s1_valid || s1_move);
        n_s1_valid = o_rec_rd || (r_s1_valid && !s1_move);
        o_empty    = (r_ocount == 2'd0);
        out_rd     = i_pop && !o_empty;
        o_data     = r_obuf[r_ord_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_owr_ptr  <= 1'b0;
            r_ord_ptr  <= 1'b0;
            r_ocount   <= 2'd0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s1_move) r_owr_ptr <= ~r_owr_ptr;
            if (out_rd)  r_ord_ptr <= ~r_ord_ptr;
            r_ocount   <= r_ocount + {1'b0, s1_move} - {1'b0, out_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_rd) r_s1 <= dec;
        if (s1_move)  r_obuf[r_owr_ptr] <= rolled;
    end

endmodule
`default_nettype wire

// ===== design/nmea_rmc_parser.sv =====
`default_nettype none
// NMEA RMC parser: takes one sentence byte per cycle (push while full is low) and
// puts one time/date/position result per RMC sentence on the result ports via the
// record queue, stage 1 and the result buffer. The byte parser never
// stalls on its own; full rises only when the two-entry record queue between the
// parser and the time/date unit is full, which happens only when results are not
// popped. The zone offset register (byte address 0, reset 8) is added to the UTC hour
// before day, month and year rollover; write it only while no sentence is in flight.
module nmea_rmc_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire nrmc_pkg::t_rmc_in  i_data,
    output logic                    empty,
    input  wire logic               pop,
    output nrmc_pkg::t_rmc_out      o_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import nrmc_pkg::*;

    logic [4:0] r_zone;
    logic       accept;
    logic       rec_wr, q_full, q_valid, q_rd;
    t_rec       rec_in, rec_out;
    logic       cfg_wr;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_ZONE);

    always_comb begin
        prdata = 32'd0;
        if (paddr[2:2] == REG_ZONE) prdata = {27'd0, r_zone};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (cfg_wr) begin
            r_zone <= pwdata[4:0];
        end
    end

    nrmc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_rec_wr (rec_wr),
        .o_rec    (rec_in)
    );

    nrmc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (rec_wr),
        .i_wr_rec (rec_in),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .i_rd     (q_rd),
        .o_rd_rec (rec_out)
    );

    nrmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_zone      (r_zone),
        .i_rec_valid (q_valid),
        .i_rec       (rec_out),
        .o_rec_rd    (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.hour < 5'd24 && o_data.minute < 6'd60 && o_data.second < 6'd60))
        else $error("result time out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.day != 5'd0 && o_data.month != 4'd0 && o_data.month <= 4'd12 &&
                    o_data.year < 7'd100))
        else $error("result date out of range");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.latitude <= 26'd60399999 && o_data.longitude <= 30'd600399999))
        else $error("result coordinate out of range");

    a_no_lost_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_wr |-> !q_full)
        else $error("sentence record written into a full queue");
`endif

endmodule
`default_nettype wire
